// ===== src/ple_pkg.sv =====
// shared types and constants for the positional list engine
// no dependencies; imported by every module of the block

package ple_pkg;

	// payload widths fixed by the word format
	localparam int DATA_W = 32;
	localparam int MODE_W = 3;
	localparam int POS_W  = 7;
	localparam int IDX_W  = 6;
	localparam int CNT_W  = 7;
	localparam int ST_W   = 2;

	// default list depth
	localparam int PLE_DEPTH = 64;

	// request operation codes
	typedef enum logic [MODE_W-1:0] {
		OP_INSERT = 3'd0,
		OP_REMOVE = 3'd1,
		OP_READ   = 3'd2,
		OP_WRITE  = 3'd3,
		OP_SEARCH = 3'd4
	} op_t;

	// response status codes
	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_t;

	// command broadcast from the sequencer to every cell
	typedef struct packed {
		logic ins;
		logic rem;
		logic wr;
		logic rot;
	} cell_cmd_t;

endpackage

// ===== src/ple_ifs.sv =====
// request and response channel interfaces for the positional list engine
// depends on nothing; widths match ple_pkg

interface ple_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic [6:0]         position;
	logic signed [31:0] data_in;

	modport source (output valid, output mode, output position, output data_in, input ready);
	modport sink   (input valid, input mode, input position, input data_in, output ready);
endinterface

interface ple_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] data_out;
	logic [5:0]         found_index;
	logic               found;
	logic [6:0]         entry_count;
	logic [1:0]         status;

	modport source (output valid, output data_out, output found_index, output found,
		output entry_count, output status, input ready);
	modport sink   (input valid, input data_out, input found_index, input found,
		input entry_count, input status, output ready);
endinterface

// ===== src/positional_list_engine_top.sv =====
// positional list engine: a row of DEPTH cells plus a sequencer
// insert, remove, write, spare-mode and flagged requests: result word in the cycle after accept
// read and search: the live entries rotate once through the row before the result word
// one request in flight; the next word is taken as the result is taken
// arst_n clears the count and the result valid; entry contents are not reset
// depends on ple_pkg, ple_ifs, ple_cell and ple_ctrl

module positional_list_engine_top import ple_pkg::*; #(
	parameter int DEPTH = PLE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	ple_req_if.sink   req,
	ple_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	cell_cmd_t                cmd;
	logic [PW-1:0]            pos;
	logic [PW-1:0]            count;
	logic signed [DATA_W-1:0] value;
	logic signed [DATA_W-1:0] cell_data [DEPTH];

	// sequencer
	ple_ctrl #(
		.DEPTH (DEPTH),
		.CW    (CW),
		.PW    (PW)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.head   (cell_data[0]),
		.cmd    (cmd),
		.pos    (pos),
		.count  (count),
		.value  (value)
	);

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_d;
		logic signed [DATA_W-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_inner
			assign right_d = cell_data[i+1];
		end

		ple_cell #(
			.PW  (PW),
			.IDX (i)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.pos   (pos),
			.count (count),
			.value (value),
			.left  (left_d),
			.right (right_d),
			.head  (cell_data[0]),
			.data  (cell_data[i])
		);
	end

endmodule

// ===== src/ple_cell.sv =====
// one list cell: holds one entry and takes data from its neighbors
// depends on ple_pkg for the command struct and data width

module ple_cell import ple_pkg::*; #(
	parameter int PW  = 7,
	parameter int IDX = 0
) (
	input  logic                     clk,
	input  cell_cmd_t                cmd,
	input  logic [PW-1:0]            pos,
	input  logic [PW-1:0]            count,
	input  logic signed [DATA_W-1:0] value,
	input  logic signed [DATA_W-1:0] left,
	input  logic signed [DATA_W-1:0] right,
	input  logic signed [DATA_W-1:0] head,
	output logic signed [DATA_W-1:0] data
);

	localparam logic [PW-1:0] IDX_V  = PW'(IDX);
	localparam logic [PW-1:0] NEXT_V = PW'(IDX + 1);

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] data_n;

	// select the next entry value from the broadcast command
	always_comb begin
		data_n = data_q;
		if (cmd.ins) begin
			if (IDX_V > pos)
				data_n = left;
			else if (IDX_V == pos)
				data_n = value;
		end else if (cmd.rem) begin
			if (IDX_V >= pos)
				data_n = right;
		end else if (cmd.wr) begin
			if (IDX_V == pos)
				data_n = value;
		end else if (cmd.rot) begin
			if (NEXT_V == count)
				data_n = head;
			else if (NEXT_V < count)
				data_n = right;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		data_q <= data_n;
	end

	assign data = data_q;

endmodule

// ===== src/ple_ctrl.sv =====
// request decoder, scan sequencer and response register
// depends on ple_pkg and the channel interfaces in ple_ifs

module ple_ctrl import ple_pkg::*; #(
	parameter int DEPTH = PLE_DEPTH,
	parameter int CW    = 7,
	parameter int PW    = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	ple_req_if.sink                  req,
	ple_rsp_if.source                rsp,
	input  logic signed [DATA_W-1:0] head,
	output cell_cmd_t                cmd,
	output logic [PW-1:0]            pos,
	output logic [PW-1:0]            count,
	output logic signed [DATA_W-1:0] value
);

	localparam logic [CW-1:0] DEPTH_V = CW'(DEPTH);

	state_t                   state_q, state_n;
	logic [CW-1:0]            count_q, count_n;
	logic                     rsp_valid_q, rsp_valid_n;
	logic signed [DATA_W-1:0] data_out_q, data_out_n;
	logic [IDX_W-1:0]         fidx_q, fidx_n;
	logic                     found_q, found_n;
	status_t                  status_q, status_n;
	op_t                      op_q, op_n;
	logic [PW-1:0]            pos_q, pos_n;
	logic signed [DATA_W-1:0] val_q, val_n;
	logic [CW-1:0]            step_q, step_n;
	logic                     hit_q, hit_n;
	logic [IDX_W-1:0]         hidx_q, hidx_n;
	logic signed [DATA_W-1:0] rd_q, rd_n;
	logic                     accept;
	logic [PW-1:0]            req_pos;
	logic [PW-1:0]            cnt_x;
	logic                     last;

	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign req_pos   = PW'(req.position);
	assign cnt_x     = PW'(count_q);
	assign last      = (CW'(step_q + 1'b1) == count_q);

	// cells see the request directly in idle, the latched one while scanning
	assign pos   = (state_q == S_IDLE) ? req_pos : pos_q;
	assign value = (state_q == S_IDLE) ? req.data_in : val_q;
	assign count = cnt_x;

	// next state, cell command and response
	always_comb begin
		state_n     = state_q;
		count_n     = count_q;
		rsp_valid_n = rsp_valid_q && !rsp.ready;
		data_out_n  = data_out_q;
		fidx_n      = fidx_q;
		found_n     = found_q;
		status_n    = status_q;
		op_n        = op_q;
		pos_n       = pos_q;
		val_n       = val_q;
		step_n      = step_q;
		hit_n       = hit_q;
		hidx_n      = hidx_q;
		rd_n        = rd_q;
		cmd         = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_n       = op_t'(req.mode);
					pos_n      = req_pos;
					val_n      = req.data_in;
					step_n     = '0;
					hit_n      = 1'b0;
					hidx_n     = '0;
					rd_n       = '0;
					data_out_n = '0;
					fidx_n     = '0;
					found_n    = 1'b0;
					status_n   = ST_OK;
					rsp_valid_n = 1'b1;
					unique case (req.mode)
						OP_INSERT: begin
							if (req_pos > cnt_x) begin
								status_n = ST_RANGE;
							end else if (count_q == DEPTH_V) begin
								status_n = ST_FULL;
							end else begin
								cmd.ins = 1'b1;
								count_n = CW'(count_q + 1'b1);
							end
						end
						OP_REMOVE: begin
							if (count_q == '0) begin
								status_n = ST_EMPTY;
							end else if (req_pos >= cnt_x) begin
								status_n = ST_RANGE;
							end else begin
								cmd.rem = 1'b1;
								count_n = CW'(count_q - 1'b1);
							end
						end
						OP_WRITE: begin
							if (count_q == '0) begin
								status_n = ST_EMPTY;
							end else if (req_pos >= cnt_x) begin
								status_n = ST_RANGE;
							end else begin
								cmd.wr = 1'b1;
							end
						end
						OP_READ: begin
							if (count_q == '0) begin
								status_n = ST_EMPTY;
							end else if (req_pos >= cnt_x) begin
								status_n = ST_RANGE;
							end else begin
								rsp_valid_n = 1'b0;
								state_n     = S_SCAN;
							end
						end
						OP_SEARCH: begin
							if (count_q == '0) begin
								status_n = ST_EMPTY;
							end else begin
								rsp_valid_n = 1'b0;
								state_n     = S_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				// rotate the live entries by one; head holds entry step_q
				cmd.rot = 1'b1;
				if (op_q == OP_READ && PW'(step_q) == pos_q)
					rd_n = head;
				if (op_q == OP_SEARCH && !hit_q && head == val_q) begin
					hit_n  = 1'b1;
					hidx_n = IDX_W'(step_q);
				end
				step_n = CW'(step_q + 1'b1);
				if (last) begin
					data_out_n  = (op_q == OP_READ) ? rd_n : '0;
					found_n     = hit_n;
					fidx_n      = hit_n ? hidx_n : '0;
					status_n    = ST_OK;
					rsp_valid_n = 1'b1;
					state_n     = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			count_q     <= count_n;
			rsp_valid_q <= rsp_valid_n;
		end
	end

	// payload and scan registers
	always_ff @(posedge clk) begin
		data_out_q <= data_out_n;
		fidx_q     <= fidx_n;
		found_q    <= found_n;
		status_q   <= status_n;
		op_q       <= op_n;
		pos_q      <= pos_n;
		val_q      <= val_n;
		step_q     <= step_n;
		hit_q      <= hit_n;
		hidx_q     <= hidx_n;
		rd_q       <= rd_n;
	end

	// response word
	assign rsp.valid       = rsp_valid_q;
	assign rsp.data_out    = data_out_q;
	assign rsp.found_index = fidx_q;
	assign rsp.found       = found_q;
	assign rsp.entry_count = CNT_W'(count_q);
	assign rsp.status      = status_q;

endmodule

// ===== src/ple_checker.sv =====
// port-level checks for the positional list engine, bound to the top level
// depends on ple_pkg for status codes

module ple_checker import ple_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] data_out,
	input logic [5:0]  found_index,
	input logic        found,
	input logic [6:0]  entry_count,
	input logic [1:0]  status
);

	// a stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(data_out) && $stable(found_index)
			&& $stable(found) && $stable(entry_count) && $stable(status))
		else $error("result word changed while stalled");

	// no new request while a result waits
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while result stalled");

	// a hit only comes with ok status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (found || found_index != 6'd0) |-> found && status == ST_OK)
		else $error("found flag inconsistent with status");

	// read data only on an ok status
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && data_out != 32'd0 |-> status == ST_OK && !found)
		else $error("read data on a flagged or search result");

endmodule

bind positional_list_engine_top ple_checker u_ple_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.data_out    (rsp.data_out),
	.found_index (rsp.found_index),
	.found       (rsp.found),
	.entry_count (rsp.entry_count),
	.status      (rsp.status)
);

// ===== test/positional_list_engine_top_tb.sv =====
// self-checking testbench for positional_list_engine_top: directed and random request words
// keeps its own copy of the list, predicts each response word and compares every field
// depends on ple_pkg, ple_ifs and the engine top level

module positional_list_engine_top_tb;
	import ple_pkg::*;

	// encodings above the last operation, which the engine must ignore
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
	localparam int POS_MAX     = (1 << POS_W) - 1;
	localparam int DRAIN_WAIT  = PLE_DEPTH + 16;
	localparam int IDLE_PCT    = 31;

	// one response word as the engine should return it
	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic [IDX_W-1:0]         idx;
		logic                     hit;
		logic [CNT_W-1:0]         count;
		status_t                  status;
	} rsp_word_t;

	logic clk;
	logic arst_n;
	logic quiet_run;
	int   mismatches;

	// shadow copy of the list contents and length
	logic signed [DATA_W-1:0] list_vals [PLE_DEPTH];
	int                       list_len;
	rsp_word_t                pending_results [$];
	rsp_word_t                want;

	ple_req_if req_if ();
	ple_rsp_if rsp_if ();

	positional_list_engine_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// 8-unit clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// apply one request to the shadow list and work out the response word
	task automatic apply_request(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
		input logic signed [DATA_W-1:0] value, output rsp_word_t w);
		int i;
		w.data   = '0;
		w.idx    = '0;
		w.hit    = 1'b0;
		w.status = ST_OK;
		case (mode)
			OP_INSERT: begin
				if (pos > list_len) begin
					w.status = ST_RANGE;
				end else if (list_len >= PLE_DEPTH) begin
					w.status = ST_FULL;
				end else begin
					for (i = list_len; i > pos; i--)
						list_vals[i] = list_vals[i-1];
					list_vals[pos] = value;
					list_len++;
				end
			end
			OP_REMOVE: begin
				if (list_len == 0) begin
					w.status = ST_EMPTY;
				end else if (pos >= list_len) begin
					w.status = ST_RANGE;
				end else begin
					for (i = pos; i < list_len - 1; i++)
						list_vals[i] = list_vals[i+1];
					list_len--;
				end
			end
			OP_READ: begin
				if (list_len == 0)
					w.status = ST_EMPTY;
				else if (pos >= list_len)
					w.status = ST_RANGE;
				else
					w.data = list_vals[pos];
			end
			OP_WRITE: begin
				if (list_len == 0)
					w.status = ST_EMPTY;
				else if (pos >= list_len)
					w.status = ST_RANGE;
				else
					list_vals[pos] = value;
			end
			OP_SEARCH: begin
				if (list_len == 0) begin
					w.status = ST_EMPTY;
				end else begin
					for (i = 0; i < list_len; i++) begin
						if (list_vals[i] == value) begin
							w.hit = 1'b1;
							w.idx = IDX_W'(i);
							break;
						end
					end
				end
			end
			default: ;
		endcase
		w.count = CNT_W'(list_len);
	endtask

	// send one request word, with random idle cycles ahead of it outside the quiet stretch
	task automatic send_word(input logic [MODE_W-1:0] mode, input int pos,
		input logic signed [DATA_W-1:0] value);
		rsp_word_t w;
		if (!quiet_run) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				req_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_if.valid    <= 1'b1;
		req_if.mode     <= mode;
		req_if.position <= pos[POS_W-1:0];
		req_if.data_in  <= value;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		apply_request(mode, pos[POS_W-1:0], value, w);
		pending_results.push_back(w);
	endtask

	// a small pool so that searches hit and duplicates occur, field extremes, or a random word
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 4))
			0, 1: return $signed($urandom_range(0, 9)) - 4;
			2:    return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// position for the chosen operation, mostly inside the list
	function automatic int pick_position(input logic [MODE_W-1:0] mode);
		if ($urandom_range(0, 99) < 15)
			return $urandom_range(0, POS_MAX);
		if (mode == OP_INSERT)
			return $urandom_range(0, list_len);
		return (list_len > 0) ? $urandom_range(0, list_len - 1) : 0;
	endfunction

	task automatic report_field(input string name, input logic [DATA_W-1:0] exp_v,
		input logic [DATA_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected 'h%0h actual 'h%0h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// response side: random stalls except during the quiet stretch
	always @(posedge clk)
		rsp_if.ready <= quiet_run || ($urandom_range(0, 99) >= IDLE_PCT);

	// compare each accepted response word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: response word with no request outstanding", $time);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				report_field("data_out", want.data, rsp_if.data_out);
				report_field("found_index", DATA_W'(want.idx), DATA_W'(rsp_if.found_index));
				report_field("found", DATA_W'(want.hit), DATA_W'(rsp_if.found));
				report_field("entry_count", DATA_W'(want.count), DATA_W'(rsp_if.entry_count));
				report_field("status", DATA_W'(want.status), DATA_W'(rsp_if.status));
			end
		end
	end

	// every operation on an empty list, plus a spare encoding
	task automatic test_empty_list();
		send_word(OP_SEARCH, 0, 32'sd0);
		send_word(OP_READ, 0, 32'sd0);
		send_word(OP_REMOVE, 0, 32'sd0);
		send_word(OP_WRITE, 0, -32'sd1);
		send_word(OP_INSERT, 1, 32'sd5);
		send_word(MODE_SPARE_LO, POS_MAX, -32'sd1);
	endtask

	// front and back inserts, field extremes, hits, misses and out-of-range positions
	task automatic test_edges();
		send_word(OP_INSERT, 0, 32'sh7fff_ffff);
		send_word(OP_INSERT, 0, 32'sh8000_0000);
		send_word(OP_INSERT, 2, -32'sd1);
		send_word(OP_INSERT, 1, 32'sd0);
		send_word(OP_INSERT, 5, 32'sd9);
		send_word(OP_READ, 0, 32'sd0);
		send_word(OP_READ, 3, 32'sd0);
		send_word(OP_READ, 4, 32'sd0);
		send_word(OP_WRITE, 2, 32'sh5555_aaaa);
		send_word(OP_WRITE, POS_MAX, 32'sd1);
		send_word(OP_SEARCH, 0, -32'sd1);
		send_word(OP_SEARCH, 0, 32'sd12345);
		send_word(OP_REMOVE, 1, 32'sd0);
		send_word(OP_REMOVE, POS_MAX, 32'sd0);
		send_word(OP_READ, 1, 32'sd0);
		send_word(MODE_SPARE_HI, 3, 32'sd7);
		send_word(OP_SEARCH, 0, 32'sh7fff_ffff);
	endtask

	// fill to capacity, probe the full list, then empty it again
	task automatic test_full_list();
		int k;
		k = 0;
		while (list_len < PLE_DEPTH) begin
			send_word(OP_INSERT, $urandom_range(0, list_len), 32'sh1000_0000 + k);
			k++;
		end
		send_word(OP_INSERT, PLE_DEPTH, 32'sd1);
		send_word(OP_INSERT, 0, 32'sd1);
		send_word(OP_INSERT, PLE_DEPTH + 1, 32'sd1);
		send_word(OP_SEARCH, 0, list_vals[PLE_DEPTH-1]);
		send_word(OP_READ, PLE_DEPTH - 1, 32'sd0);
		send_word(OP_READ, PLE_DEPTH, 32'sd0);
		while (list_len > 0)
			send_word(OP_REMOVE, $urandom_range(0, list_len - 1), 32'sd0);
		send_word(OP_REMOVE, 0, 32'sd0);
	endtask

	// random mix; weights set whether the list tends to grow or shrink
	task automatic test_random_mix(input int n, input int ins_w, input int rem_w);
		int i;
		int r;
		logic [MODE_W-1:0] mode;
		logic signed [DATA_W-1:0] value;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
			else if (r < 3 + ins_w)
				mode = OP_INSERT;
			else if (r < 3 + ins_w + rem_w)
				mode = OP_REMOVE;
			else
				case ($urandom_range(0, 2))
					0: mode = OP_READ;
					1: mode = OP_WRITE;
					default: mode = OP_SEARCH;
				endcase
			value = pick_value();
			if (mode == OP_SEARCH && list_len > 0 && $urandom_range(0, 99) < 60)
				value = list_vals[$urandom_range(0, list_len - 1)];
			send_word(mode, pick_position(mode), value);
		end
	endtask

	// hard stop in case the engine hangs
	initial begin
		#5_000_000;
		$display("positional_list_engine_top_tb: FAIL");
		$finish;
	end

	initial begin
		mismatches = 0;
		list_len   = 0;
		quiet_run  = 1'b0;
		arst_n          <= 1'b0;
		req_if.valid    <= 1'b0;
		req_if.mode     <= OP_INSERT;
		req_if.position <= '0;
		req_if.data_in  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_edges();
		test_full_list();
		quiet_run = 1'b1;
		test_random_mix(60, 40, 25);
		quiet_run = 1'b0;
		test_random_mix(80, 55, 15);
		test_random_mix(80, 15, 50);
		test_random_mix(70, 35, 35);
		req_if.valid <= 1'b0;

		// drain outstanding responses, then let the engine settle
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("positional_list_engine_top_tb: PASS");
		else
			$display("positional_list_engine_top_tb: FAIL");
		$finish;
	end

endmodule
